>>> hw/rtl/wpq_pkg.sv
`default_nettype none

package wpq_pkg;

   // scale geometry
   localparam int SEMIS        = 12;
   localparam int OCTAVE_CENTS = 1200;
   localparam int SEMI_CENTS   = 100;
   localparam int OCTAVE_SPAN  = 3;
   localparam int NUM_CELLS    = OCTAVE_SPAN * SEMIS;
   localparam int DIST_MAX     = 4095;

   // reciprocal of 1200 for magnitudes up to 16384: floor(m * RECIP >> RECIP_SHIFT)
   localparam int RECIP       = 27963;
   localparam int RECIP_SHIFT = 25;

   // reciprocal of 12 for values up to 146, and the bias that keeps the sum positive
   localparam int MOD12_RECIP = 171;
   localparam int MOD12_SHIFT = 11;
   localparam int MOD12_BIAS  = 72;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_WEIGHTS_LO = 2'd0,
      CSR_WEIGHTS_HI = 2'd1,
      CSR_TRANSPOSE  = 2'd2
   } csr_index_type;

   // one item as it moves down the chain of cells, with the running best candidate
   typedef struct packed {
      logic               valid;
      logic signed [14:0] pitch;
      logic signed [15:0] base;   // cents of the octave below the pitch's octave
      logic               found;
      logic signed [17:0] score;
      logic signed [16:0] cand;
      logic        [15:0] distance;
      logic        [7:0]  weight;
      logic        [3:0]  semi;
   } lane_type;

endpackage

`default_nettype wire

>>> hw/rtl/wpq_front.sv
`default_nettype none

// Octave split: pitch / 1200 toward zero, then the lowest candidate octave in cents.
module wpq_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               valid_in,
   input  wire logic signed [14:0] pitch_in,
   output wpq_pkg::lane_type       lane_out
);

   localparam logic [14:0] RECIP_K = 15'(wpq_pkg::RECIP);

   logic               s1_valid_ff;
   logic signed [14:0] s1_pitch_ff;
   logic               s1_neg_ff;
   logic        [3:0]  s1_quot_ff;
   logic        [3:0]  s1_quot_in;
   logic        [15:0] mag;
   logic        [30:0] prod;

   wpq_pkg::lane_type  s2_ff;
   wpq_pkg::lane_type  s2_in;
   logic signed [4:0]  oct;
   logic signed [4:0]  oct_below;

   // stage 1: magnitude quotient by reciprocal multiply
   always_comb begin
      mag        = pitch_in[14] ? 16'(-{pitch_in[14], pitch_in}) : {1'b0, pitch_in};
      prod       = 31'(mag) * 31'(RECIP_K);
      s1_quot_in = prod[wpq_pkg::RECIP_SHIFT +: 4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= valid_in;
         s1_pitch_ff <= pitch_in;
         s1_neg_ff   <= pitch_in[14];
         s1_quot_ff  <= s1_quot_in;
      end
   end

   // stage 2: signed octave, base of the octave below, empty running best
   always_comb begin
      oct       = s1_neg_ff ? -$signed({1'b0, s1_quot_ff}) : $signed({1'b0, s1_quot_ff});
      oct_below = oct - 5'sd1;
      s2_in        = '0;
      s2_in.valid  = s1_valid_ff;
      s2_in.pitch  = s1_pitch_ff;
      s2_in.base   = 16'(oct_below * 16'sd1200);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (enable) begin
         s2_ff <= s2_in;
      end
   end

   assign lane_out = s2_ff;

endmodule

`default_nettype wire

>>> hw/rtl/wpq_cell.sv
`default_nettype none

// One candidate: scores it against the pitch and keeps the better of it and the running best.
module wpq_cell (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire logic [11:0] cand_offset,
   input  wire logic [3:0]  cand_semi,
   input  wire logic [7:0]  weight,
   input  wire wpq_pkg::lane_type lane_in,
   output wpq_pkg::lane_type lane_out
);

   wpq_pkg::lane_type  lane_ff;
   wpq_pkg::lane_type  lane_in_next;
   logic signed [16:0] cand;
   logic signed [17:0] diff;
   logic        [15:0] distance;
   logic signed [17:0] score;
   logic               take;

   always_comb begin
      cand     = 17'(lane_in.base) + $signed({5'b0, cand_offset});
      diff     = 18'(lane_in.pitch) - 18'(cand);
      distance = diff[17] ? 16'(-diff) : diff[15:0];
      score    = $signed({10'b0, weight}) * 18'sd12 - $signed({2'b0, distance});
      // earlier candidates win ties
      take     = (weight != 8'd0) && (!lane_in.found || (score > lane_in.score));

      lane_in_next = lane_in;
      if (take) begin
         lane_in_next.found    = 1'b1;
         lane_in_next.score    = score;
         lane_in_next.cand     = cand;
         lane_in_next.distance = distance;
         lane_in_next.weight   = weight;
         lane_in_next.semi     = cand_semi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (enable) begin
         lane_ff <= lane_in_next;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

>>> hw/rtl/wpq_back.sv
`default_nettype none

// Result formatting: transpose, note index modulo 12, distance clamp, output register.
module wpq_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic signed [6:0]  transpose,
   input  wire wpq_pkg::lane_type  lane_in,
   output logic                    rsp_valid,
   output logic [63:0]             rsp_data,
   output logic                    rsp_found
);

   localparam logic [11:0] DIST_CLAMP = 12'(wpq_pkg::DIST_MAX);

   logic               valid_ff;
   logic [63:0]        data_ff;
   logic [63:0]        data_in;
   logic               found_ff;

   logic signed [16:0] chosen;
   logic signed [13:0] shift_cents;
   logic signed [16:0] final_sum;
   logic        [14:0] quant;
   logic        [7:0]  biased;
   logic        [14:0] mod_prod;
   logic        [3:0]  mod_quot;
   logic        [7:0]  mod_rem;
   logic        [3:0]  note_idx;
   logic        [3:0]  final_idx;
   logic        [7:0]  weight;
   logic        [11:0] distance;

   always_comb begin
      chosen      = lane_in.found ? lane_in.cand : 17'(lane_in.pitch);
      shift_cents = 14'(transpose) * 14'sd100;
      final_sum   = chosen + 17'(shift_cents);
      quant       = lane_in.found ? lane_in.cand[14:0] : lane_in.pitch;

      // (semi + transpose) mod 12 over a positive bias
      biased   = 8'(lane_in.semi) + 8'(transpose) + 8'(wpq_pkg::MOD12_BIAS);
      mod_prod = 15'(biased) * 15'(wpq_pkg::MOD12_RECIP);
      mod_quot = mod_prod[wpq_pkg::MOD12_SHIFT +: 4];
      mod_rem  = biased - 8'(mod_quot) * 8'd12;

      note_idx  = lane_in.found ? lane_in.semi   : 4'd0;
      final_idx = lane_in.found ? mod_rem[3:0]   : 4'd0;
      weight    = lane_in.found ? lane_in.weight : 8'd0;
      if (!lane_in.found) begin
         distance = 12'd0;
      end else if (lane_in.distance > 16'(DIST_CLAMP)) begin
         distance = DIST_CLAMP;
      end else begin
         distance = lane_in.distance[11:0];
      end

      data_in = {5'b0, distance, weight, final_idx, note_idx, final_sum[15:0], quant};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= lane_in.valid;
         data_ff  <= data_in;
         found_ff <= lane_in.found;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign rsp_found = found_ff;

endmodule

`default_nettype wire

>>> hw/rtl/weighted_pitch_quantizer.sv
// Weighted 12-tone pitch quantizer.
// Input items on req_* carry a pitch in cents (1200 per octave). Each item runs down a
// row of 36 cells, one per candidate note (octave below, same, above, times 12
// semitones); each cell scores its candidate as 12 * weight - distance and keeps the
// best so far, earlier candidates winning ties. Result items on rsp_* carry the chosen
// pitch, the transposed pitch, note indices, weight and distance.
// Throughput: one item per cycle while the receiver does not stall. Each item passes
// through two octave-split stages, 36 cells and one output register.
// The csr_* port writes the weight and transpose registers; write only while no item is
// in flight. Reset clears all valid state and the configuration registers to zero (no
// weights, so items pass through with the found flag low).
// When the receiver stalls with a result waiting, the whole row holds, bubbles
// included, and req_tready stays low until that result is taken.
`default_nettype none

module weighted_pitch_quantizer (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [14:0] pitch_cents
   // result item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [14:0] quantized_cents, [30:15] final_cents,
                                          // [34:31] note_index, [38:35] final_note_index,
                                          // [46:39] chosen_weight, [58:47] distance_cents
   output logic             rsp_tuser,   // [0] note_found
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   logic [47:0]       weights_lo_ff;
   logic [47:0]       weights_hi_ff;
   logic signed [6:0] transpose_ff;
   logic              enable;

   wpq_pkg::lane_type lanes [wpq_pkg::NUM_CELLS + 1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weights_lo_ff <= '0;
         weights_hi_ff <= '0;
         transpose_ff  <= '0;
      end else if (csr_we) begin
         unique case (wpq_pkg::csr_index_type'(csr_index))
            wpq_pkg::CSR_WEIGHTS_LO: weights_lo_ff <= csr_wdata;
            wpq_pkg::CSR_WEIGHTS_HI: weights_hi_ff <= csr_wdata;
            wpq_pkg::CSR_TRANSPOSE:  transpose_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // whole row advances unless a result waits on a stalled receiver
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   wpq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .valid_in (req_tvalid),
      .pitch_in (req_tdata[14:0]),
      .lane_out (lanes[0])
   );

   // row of candidate cells, octave-major, semitone-minor
   for (genvar i = 0; i < wpq_pkg::NUM_CELLS; i++) begin : g_cell
      localparam int SEMI = i % wpq_pkg::SEMIS;
      localparam int OCTI = i / wpq_pkg::SEMIS;
      localparam logic [11:0] OFFSET =
         12'(OCTI * wpq_pkg::OCTAVE_CENTS + SEMI * wpq_pkg::SEMI_CENTS);

      logic [7:0] weight;

      if (SEMI < 6) begin : g_lo
         assign weight = weights_lo_ff[8 * SEMI +: 8];
      end else begin : g_hi
         assign weight = weights_hi_ff[8 * (SEMI - 6) +: 8];
      end

      wpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .cand_offset (OFFSET),
         .cand_semi   (4'(SEMI)),
         .weight      (weight),
         .lane_in     (lanes[i]),
         .lane_out    (lanes[i + 1])
      );
   end

   wpq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .transpose (transpose_ff),
      .lane_in   (lanes[wpq_pkg::NUM_CELLS]),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata),
      .rsp_found (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> verif/wpq_result_check.sv
`timescale 1ns / 100ps

module wpq_result_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [14:0] pitch_cents
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // [14:0] quantized_cents, [30:15] final_cents,
                                          // [34:31] note_index, [38:35] final_note_index,
                                          // [46:39] chosen_weight, [58:47] distance_cents
   input  wire logic        rsp_tuser,   // [0] note_found
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata,
   output int               mismatches,
   output int               outstanding
);

   localparam int NOTES_PER_OCTAVE = 12;
   localparam int CENTS_PER_OCTAVE = 1200;
   localparam int CENTS_PER_NOTE   = 100;
   localparam int WEIGHT_GAIN      = 12;
   localparam int DISTANCE_LIMIT   = 4095;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [14:0] quantized;
      logic [15:0] final_cents;
      logic        found;
      logic [3:0]  note;
      logic [3:0]  final_note;
      logic [7:0]  weight;
      logic [11:0] distance;
   } pitch_result_type;

   // shadow copy of the scale registers
   logic [47:0]        weights_lo;
   logic [47:0]        weights_hi;
   logic signed [6:0]  transpose;

   pitch_result_type   pending_results[$];
   pitch_result_type   got;
   pitch_result_type   want;

   // search all 36 candidates around the pitch's octave, first best wins
   function automatic pitch_result_type quantize_pitch(logic [14:0] pitch_bits);
      int               pitch, shift, octave, cand, gap, score, w, fi;
      int               best_score, best_cand, best_dist, best_semi, best_w, shifted;
      logic [95:0]      weights;
      bit               found;
      pitch_result_type r;
      pitch      = $signed(pitch_bits);
      shift      = transpose;
      octave     = pitch / CENTS_PER_OCTAVE;   // truncates toward zero
      weights    = {weights_hi, weights_lo};
      found      = 1'b0;
      best_score = 0;
      best_cand  = pitch;
      best_dist  = 0;
      best_semi  = 0;
      best_w     = 0;
      for (int k = -1; k <= 1; k++) begin
         for (int s = 0; s < NOTES_PER_OCTAVE; s++) begin
            w = weights[8*s +: 8];
            if (w != 0) begin
               cand  = (octave + k) * CENTS_PER_OCTAVE + s * CENTS_PER_NOTE;
               gap   = (pitch > cand) ? pitch - cand : cand - pitch;
               score = WEIGHT_GAIN * w - gap;
               if (!found || score > best_score) begin
                  found      = 1'b1;
                  best_score = score;
                  best_cand  = cand;
                  best_dist  = gap;
                  best_w     = w;
                  best_semi  = s;
               end
            end
         end
      end
      r             = '0;
      r.quantized   = best_cand[14:0];
      shifted       = best_cand + CENTS_PER_NOTE * shift;
      r.final_cents = shifted[15:0];
      if (found) begin
         // true modulo so negative transposes land in 0..11
         fi = (best_semi + shift) % NOTES_PER_OCTAVE;
         if (fi < 0)
            fi += NOTES_PER_OCTAVE;
         r.found      = 1'b1;
         r.note       = best_semi[3:0];
         r.final_note = fi[3:0];
         r.weight     = best_w[7:0];
         r.distance   = (best_dist > DISTANCE_LIMIT) ? DISTANCE_LIMIT[11:0] : best_dist[11:0];
      end
      return r;
   endfunction

   function automatic string describe(pitch_result_type r);
      return $sformatf({"quantized=%0d final=%0d found=%0b note=%0d ",
                        "final_note=%0d weight=%0d dist=%0d"},
                       $signed(r.quantized), $signed(r.final_cents), r.found, r.note,
                       r.final_note, r.weight, r.distance);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         weights_lo  = '0;
         weights_hi  = '0;
         transpose   = '0;
         pending_results.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         // predict each accepted item with the scale in force now
         if (req_tvalid && req_tready)
            pending_results.push_back(quantize_pitch(req_tdata[14:0]));

         // compare each delivered result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.quantized   = rsp_tdata[14:0];
            got.final_cents = rsp_tdata[30:15];
            got.note        = rsp_tdata[34:31];
            got.final_note  = rsp_tdata[38:35];
            got.weight      = rsp_tdata[46:39];
            got.distance    = rsp_tdata[58:47];
            got.found       = rsp_tuser;
            if (pending_results.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: result item with nothing pending: %s", $time, describe(got));
               mismatches <= mismatches + 1;
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: result item differs", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end

         // register writes take effect for later items
         if (csr_we) begin
            case (wpq_pkg::csr_index_type'(csr_index))
               wpq_pkg::CSR_WEIGHTS_LO: weights_lo = csr_wdata;
               wpq_pkg::CSR_WEIGHTS_HI: weights_hi = csr_wdata;
               wpq_pkg::CSR_TRANSPOSE:  transpose  = csr_wdata[6:0];
               default: ;
            endcase
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

>>> verif/tb_weighted_pitch_quantizer.sv
`timescale 1ns / 100ps

module tb_weighted_pitch_quantizer;

   localparam int ITEMS_PER_PHASE = 124;
   localparam int RANDOM_PHASES   = 13;
   localparam int DRAIN_CYCLES    = 45;

   typedef enum int {
      SCALE_SINGLE,
      SCALE_SPARSE,
      SCALE_DENSE
   } scale_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [14:0] pitch_cents
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [63:0] rsp_tdata;         // [14:0] quantized_cents, [30:15] final_cents,
                                   // [34:31] note_index, [38:35] final_note_index,
                                   // [46:39] chosen_weight, [58:47] distance_cents
   logic        rsp_tuser;         // [0] note_found
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = wpq_pkg::CSR_WEIGHTS_LO;
   logic [47:0] csr_wdata  = '0;
   bit          quiet      = 1'b0;
   int          mismatches;
   int          outstanding;

   // pitches for the unwritten scale, then for equal weights with the lowest transpose
   int empty_scale_pitches[4] = '{0, -12000, 12000, -16384};
   int edge_pitches[17] = '{0, 1, -1, 50, -50, 150, 599, 600, 601, -1199, -1200,
                            1199, 1200, 12000, -12000, 16383, -16384};

   weighted_pitch_quantizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wpq_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver stalls in bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // write all three registers once the row has emptied
   task automatic set_scale(input logic [95:0] weights, input int shift);
      while (outstanding != 0) @(negedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= wpq_pkg::CSR_WEIGHTS_LO;
      csr_wdata <= weights[47:0];
      @(negedge clock);
      csr_index <= wpq_pkg::CSR_WEIGHTS_HI;
      csr_wdata <= weights[95:48];
      @(negedge clock);
      csr_index <= wpq_pkg::CSR_TRANSPOSE;
      csr_wdata <= 48'(shift[6:0]);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // one pitch item, with an optional idle burst ahead of it
   task automatic send_pitch(input int pitch);
      logic [14:0] bits;
      bits = pitch[14:0];
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, bits};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly in range, some within 3 cents of a note, a few over the whole field
   function automatic int random_pitch();
      int p;
      case ($urandom_range(0, 9))
         0:       p = $signed(15'($urandom_range(0, 32767)));
         1, 2:    p = (int'($urandom_range(0, 20)) - 10) * 1200
                      + int'($urandom_range(0, 11)) * 100 + int'($urandom_range(0, 6)) - 3;
         default: p = int'($urandom_range(0, 24000)) - 12000;
      endcase
      return p;
   endfunction

   function automatic logic [95:0] random_weights(scale_kind_type kind);
      logic [95:0] w;
      w = '0;
      case (kind)
         SCALE_SINGLE: w[8*$urandom_range(0, 11) +: 8] = 8'($urandom_range(1, 255));
         SCALE_SPARSE: begin
            for (int s = 0; s < 12; s++)
               if ($urandom_range(0, 1) == 1)
                  w[8*s +: 8] = 8'($urandom_range(1, 255));
         end
         default: begin
            // small codes make ties between candidates likely
            for (int s = 0; s < 12; s++)
               w[8*s +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 3))
                                                         : 8'($urandom_range(1, 255));
         end
      endcase
      return w;
   endfunction

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // no weights written: items pass through
      foreach (empty_scale_pitches[i])
         send_pitch(empty_scale_pitches[i]);
      req_tvalid <= 1'b0;

      // equal weights: every candidate ties on weight
      set_scale({12{8'h01}}, -60);
      foreach (edge_pitches[i])
         send_pitch(edge_pitches[i]);
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0)
            set_scale({12{8'hff}}, 60);
         else if (ph == 1)
            set_scale('0, int'($urandom_range(0, 120)) - 60);
         else if (ph == 2)
            set_scale(random_weights(SCALE_SINGLE), -60);
         else
            set_scale(random_weights(scale_kind_type'($urandom_range(SCALE_SINGLE, SCALE_DENSE))),
                      int'($urandom_range(0, 120)) - 60);
         quiet = (ph == RANDOM_PHASES - 1);
         repeat (ITEMS_PER_PHASE)
            send_pitch(random_pitch());
         req_tvalid <= 1'b0;
      end

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> weighted_pitch_quantizer.f
hw/rtl/wpq_pkg.sv
hw/rtl/wpq_front.sv
hw/rtl/wpq_cell.sv
hw/rtl/wpq_back.sv
hw/rtl/weighted_pitch_quantizer.sv
verif/wpq_result_check.sv
verif/tb_weighted_pitch_quantizer.sv
